>>> src/dhcpoc_pkg.sv
// Shared types, field positions, codes and check functions for the DHCP offer checker.
package dhcpoc_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SEC_W   = 20;
  localparam int unsigned PFX_W   = 6;
  localparam int unsigned RSN_W   = 3;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_ADDR_LSB    = 0;
  localparam int unsigned IN_SERVER_LSB  = 32;
  localparam int unsigned IN_MASK_LSB    = 64;
  localparam int unsigned IN_LEASE_LSB   = 96;
  localparam int unsigned IN_T1_LSB      = 128;
  localparam int unsigned IN_T1_GIVEN    = 160;
  localparam int unsigned IN_T2_LSB      = 161;
  localparam int unsigned IN_T2_GIVEN    = 193;
  localparam int unsigned IN_CAP_LSB     = 194;
  localparam int unsigned IN_TDATA_W     = 232;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OUT_ACC_BIT    = 0;
  localparam int unsigned OUT_RSN_LSB    = 1;
  localparam int unsigned OUT_LEASE_LSB  = 4;
  localparam int unsigned OUT_T1_LSB     = 24;
  localparam int unsigned OUT_T2_LSB     = 44;
  localparam int unsigned OUT_PFX_LSB    = 64;
  localparam int unsigned OUT_TDATA_W    = 72;

  localparam logic [SEC_W-1:0] MAX_LEASE_RESET = 20'd604800;

  // Commands carried in tuser.
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_CAP   = 1'b1;

  // Reject reasons; the first failing check wins.
  localparam logic [RSN_W-1:0] RSN_OK        = 3'd0;
  localparam logic [RSN_W-1:0] RSN_BAD_ADDR  = 3'd1;
  localparam logic [RSN_W-1:0] RSN_BAD_SRV   = 3'd2;
  localparam logic [RSN_W-1:0] RSN_BAD_MASK  = 3'd3;
  localparam logic [RSN_W-1:0] RSN_NET_BCAST = 3'd4;
  localparam logic [RSN_W-1:0] RSN_ZERO_LEAS = 3'd5;

  localparam logic [7:0] LOOPBACK_NET  = 8'd127;
  localparam logic [3:0] MCAST_NIBBLE  = 4'hE;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic               cmd;
    logic [RSN_W-1:0]   reason;
    logic [SEC_W-1:0]   lease;     // clamped lease for a check
    logic [PFX_W-1:0]   prefix;
    logic [ADDR_W-1:0]  t1;
    logic               t1_given;
    logic [ADDR_W-1:0]  t2;
    logic               t2_given;
    logic [ADDR_W-1:0]  cap;
  } offer_item_t;

  // Result fields as held in the output register.
  typedef struct packed {
    logic               accepted;
    logic [RSN_W-1:0]   reason;
    logic [SEC_W-1:0]   lease;
    logic [SEC_W-1:0]   renewal;
    logic [SEC_W-1:0]   rebinding;
    logic [PFX_W-1:0]   prefix;
  } offer_result_t;

  function automatic logic usable_host(input logic [ADDR_W-1:0] a);
    usable_host = (a != '0) && (a[31:24] != LOOPBACK_NET) &&
                  (a[31:28] != MCAST_NIBBLE) && (a != '1);
  endfunction

  function automatic logic [PFX_W-1:0] ones_count(input logic [ADDR_W-1:0] v);
    logic [PFX_W-1:0] n;
    n = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      n = n + PFX_W'(v[i]);
    end
    ones_count = n;
  endfunction

endpackage

>>> src/dhcpoc_front.sv
// Front end: unpacks an offer, checks address, server, mask, net/broadcast and lease, clamps the lease.
module dhcpoc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dhcpoc_pkg::IN_TDATA_W-1:0]  in_data,
  input  logic                               in_cmd,
  input  logic [dhcpoc_pkg::SEC_W-1:0]       max_lease,
  output logic                               item_valid,
  input  logic                               item_ready,
  output dhcpoc_pkg::offer_item_t            item
);

  logic [31:0] addr, server, mask, lease, inv;
  logic        mask_good, host_many, net_or_bc;
  logic [dhcpoc_pkg::RSN_W-1:0] reason;
  logic [dhcpoc_pkg::SEC_W-1:0] clamped;

  logic                    valid_r, valid_nxt;
  dhcpoc_pkg::offer_item_t item_r, item_nxt;

  assign addr   = in_data[dhcpoc_pkg::IN_ADDR_LSB   +: 32];
  assign server = in_data[dhcpoc_pkg::IN_SERVER_LSB +: 32];
  assign mask   = in_data[dhcpoc_pkg::IN_MASK_LSB   +: 32];
  assign lease  = in_data[dhcpoc_pkg::IN_LEASE_LSB  +: 32];
  assign inv    = ~mask;

  // A contiguous mask has an inverse of the form 0..01..1.
  assign mask_good = (mask != '0) && ((inv & (inv + 32'd1)) == '0);
  assign host_many = (inv[31:1] != '0);
  assign net_or_bc = ((addr & inv) == '0) || ((addr & inv) == inv);
  assign clamped   = (lease < {12'd0, max_lease}) ? lease[dhcpoc_pkg::SEC_W-1:0] : max_lease;

  always_comb begin
    if (in_cmd == dhcpoc_pkg::CMD_CAP) begin
      reason = dhcpoc_pkg::RSN_OK;
    end else if (!dhcpoc_pkg::usable_host(addr)) begin
      reason = dhcpoc_pkg::RSN_BAD_ADDR;
    end else if (!dhcpoc_pkg::usable_host(server)) begin
      reason = dhcpoc_pkg::RSN_BAD_SRV;
    end else if (!mask_good) begin
      reason = dhcpoc_pkg::RSN_BAD_MASK;
    end else if (host_many && net_or_bc) begin
      reason = dhcpoc_pkg::RSN_NET_BCAST;
    end else if (lease == '0) begin
      reason = dhcpoc_pkg::RSN_ZERO_LEAS;
    end else begin
      reason = dhcpoc_pkg::RSN_OK;
    end
  end

  assign in_ready = !valid_r || item_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt         = in_valid;
      item_nxt.cmd      = in_cmd;
      item_nxt.reason   = reason;
      item_nxt.lease    = clamped;
      item_nxt.prefix   = dhcpoc_pkg::ones_count(mask);
      item_nxt.t1       = in_data[dhcpoc_pkg::IN_T1_LSB +: 32];
      item_nxt.t1_given = in_data[dhcpoc_pkg::IN_T1_GIVEN];
      item_nxt.t2       = in_data[dhcpoc_pkg::IN_T2_LSB +: 32];
      item_nxt.t2_given = in_data[dhcpoc_pkg::IN_T2_GIVEN];
      item_nxt.cap      = in_data[dhcpoc_pkg::IN_CAP_LSB +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> src/dhcpoc_queue.sv
// Two-entry queue of classified items between the front end and the back end.
module dhcpoc_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_valid,
  output logic                    wr_ready,
  input  dhcpoc_pkg::offer_item_t wr_item,
  output logic                    rd_valid,
  input  logic                    rd_ready,
  output dhcpoc_pkg::offer_item_t rd_item
);

  dhcpoc_pkg::offer_item_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> src/dhcpoc_back.sv
// Back end: applies an item to the stored lease, timers and prefix and registers the result.
module dhcpoc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  dhcpoc_pkg::offer_item_t item,
  output logic                    res_valid,
  input  logic                    res_ready,
  output dhcpoc_pkg::offer_result_t res
);

  logic [dhcpoc_pkg::SEC_W-1:0] lease_r, lease_nxt;
  logic [dhcpoc_pkg::SEC_W-1:0] renew_r, renew_nxt;
  logic [dhcpoc_pkg::SEC_W-1:0] rebind_r, rebind_nxt;
  logic [dhcpoc_pkg::PFX_W-1:0] prefix_r, prefix_nxt;
  logic                         res_valid_r, res_valid_nxt;
  dhcpoc_pkg::offer_result_t    res_r, res_nxt;

  logic        is_cap, check_ok, cap_hit, take;
  logic [dhcpoc_pkg::SEC_W-1:0] tl, def1, def2;
  logic [dhcpoc_pkg::SEC_W+2:0] tl7;
  logic [31:0] r1, r2, tl_w;
  logic        fall_back;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;

  assign is_cap   = (item.cmd == dhcpoc_pkg::CMD_CAP);
  assign check_ok = !is_cap && (item.reason == dhcpoc_pkg::RSN_OK);
  // A cap below the stored lease is itself below 2^20, so it is taken as is.
  assign cap_hit  = is_cap && (item.cap != '0) && ({12'd0, lease_r} > item.cap);

  // New lease the timers are derived from.
  assign tl   = is_cap ? item.cap[dhcpoc_pkg::SEC_W-1:0] : item.lease;
  assign tl_w = {12'd0, tl};
  assign def1 = tl >> 1;
  assign tl7  = {tl, 3'b000} - {3'b000, tl};
  assign def2 = tl7[dhcpoc_pkg::SEC_W+2:3];

  // Server timers survive only when T1 < T2 < lease.
  assign r1 = (!is_cap && item.t1_given) ? item.t1 : {12'd0, def1};
  assign r2 = (!is_cap && item.t2_given) ? item.t2 : {12'd0, def2};
  assign fall_back = (r1 >= tl_w) || (r2 >= tl_w) || (r2 <= r1);

  always_comb begin
    lease_nxt     = lease_r;
    renew_nxt     = renew_r;
    rebind_nxt    = rebind_r;
    prefix_nxt    = prefix_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    if (take) begin
      if (check_ok || cap_hit) begin
        lease_nxt  = tl;
        renew_nxt  = fall_back ? def1 : r1[dhcpoc_pkg::SEC_W-1:0];
        rebind_nxt = fall_back ? def2 : r2[dhcpoc_pkg::SEC_W-1:0];
      end
      if (check_ok) begin
        prefix_nxt = item.prefix;
      end
      res_valid_nxt     = 1'b1;
      res_nxt.accepted  = check_ok || cap_hit;
      res_nxt.reason    = is_cap ? dhcpoc_pkg::RSN_OK : item.reason;
      res_nxt.lease     = lease_nxt;
      res_nxt.renewal   = renew_nxt;
      res_nxt.rebinding = rebind_nxt;
      res_nxt.prefix    = prefix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_r     <= '0;
      renew_r     <= '0;
      rebind_r    <= '0;
      prefix_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      lease_r     <= lease_nxt;
      renew_r     <= renew_nxt;
      rebind_r    <= rebind_nxt;
      prefix_r    <= prefix_nxt;
      res_valid_r <= res_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> src/dhcp_offer_check_and_timers.sv
// Top level of the DHCP offer checker and lease timer keeper.
// An item passes the front-end register, the queue and then the result register before out_tvalid rises.
// Throughput: one item per cycle unless out_tready stalls the result; the back end updates its state per item.
// The two-entry queue lets the front end keep taking items while a result waits downstream.
// Synchronous active-low reset clears the stored lease, timers and prefix to zero, empties the
// pipeline and loads the maximum lease register with 604800 seconds.
module dhcp_offer_check_and_timers (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration: maximum lease in seconds.
  input  logic                               cfg_wr_en,
  input  logic [dhcpoc_pkg::SEC_W-1:0]       cfg_wr_data,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata, lowest bit up: offered_address[31:0], server_address[63:32], subnet_mask[95:64],
  // lease_time[127:96], renewal_time[159:128], renewal_given[160], rebinding_time[192:161],
  // rebinding_given[193], cap_seconds[225:194], zero padding[231:226].
  input  logic [dhcpoc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: command[0] (0 check offer, 1 cap stored lease).
  input  logic                               in_tuser,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, lowest bit up: accepted[0], reject_reason[3:1], lease_out[23:4],
  // renewal_out[43:24], rebinding_out[63:44], prefix_out[69:64], zero padding[71:70].
  output logic [dhcpoc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [dhcpoc_pkg::SEC_W-1:0] max_lease_r, max_lease_nxt;

  // The user must rewrite the maximum lease only while the pipeline is empty; the block does not enforce this.
  always_comb begin
    max_lease_nxt = cfg_wr_en ? cfg_wr_data : max_lease_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lease_r <= dhcpoc_pkg::MAX_LEASE_RESET;
    end else begin
      max_lease_r <= max_lease_nxt;
    end
  end

  logic                      fr_valid, fr_ready;
  dhcpoc_pkg::offer_item_t   fr_item;
  logic                      q_valid, q_ready;
  dhcpoc_pkg::offer_item_t   q_item;
  dhcpoc_pkg::offer_result_t res;

  // The front end classifies each offer and clamps its lease; of stored state it reads only the maximum lease.
  dhcpoc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_cmd     (in_tuser),
    .max_lease  (max_lease_r),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  // Decouples the two halves so either side can stall without stopping the other at once.
  dhcpoc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // The back end owns the stored lease, timers and prefix, so cap commands see the
  // lease left by the item just before them.
  dhcpoc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {2'b00, res.prefix, res.rebinding, res.renewal, res.lease,
                      res.reason, res.accepted};

endmodule

>>> src/dhcpoc_checker.sv
// Port-level assertions for the DHCP offer checker and their bind to the top level.
module dhcpoc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [dhcpoc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                         acc;
  logic [dhcpoc_pkg::RSN_W-1:0] rsn;
  logic [dhcpoc_pkg::SEC_W-1:0] lease, renewal, rebinding;

  assign acc       = out_tdata[dhcpoc_pkg::OUT_ACC_BIT];
  assign rsn       = out_tdata[dhcpoc_pkg::OUT_RSN_LSB   +: dhcpoc_pkg::RSN_W];
  assign lease     = out_tdata[dhcpoc_pkg::OUT_LEASE_LSB +: dhcpoc_pkg::SEC_W];
  assign renewal   = out_tdata[dhcpoc_pkg::OUT_T1_LSB    +: dhcpoc_pkg::SEC_W];
  assign rebinding = out_tdata[dhcpoc_pkg::OUT_T2_LSB    +: dhcpoc_pkg::SEC_W];

  // A stalled result keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An accepted item never carries a reject reason.
  a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && acc |-> rsn == dhcpoc_pkg::RSN_OK)
    else $error("accepted result with a reject reason");

  // Stored timers always stay ordered under the stored lease.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (renewal <= rebinding) && (rebinding <= lease))
    else $error("stored timers out of order");

endmodule

bind dhcp_offer_check_and_timers dhcpoc_checker u_dhcpoc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/offer_lease_checker.sv
// Checker for the DHCP offer checker: predicts each result from the input transfers and compares.
`timescale 1ns / 1ps

module offer_lease_checker
  import dhcpoc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [SEC_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    logic        cmd;
    logic [31:0] addr;
    logic [31:0] server;
    logic [31:0] mask;
    logic [31:0] lease;
    logic [31:0] t1;
    logic        t1_given;
    logic [31:0] t2;
    logic        t2_given;
    logic [31:0] cap;
  } offer_fields_t;

  // Local copy of the block's register and lease state.
  logic [SEC_W-1:0] max_lease;
  logic [SEC_W-1:0] held_lease;
  logic [SEC_W-1:0] held_renewal;
  logic [SEC_W-1:0] held_rebinding;
  logic [PFX_W-1:0] held_prefix;

  offer_result_t pending_results[$];

  function automatic bit host_usable(input logic [31:0] a);
    return (a != 32'd0) && (a[31:24] != LOOPBACK_NET) && (a[31:28] != MCAST_NIBBLE) &&
           (a != 32'hFFFF_FFFF);
  endfunction

  // Server timers survive only when strictly ordered below the stored lease.
  task automatic load_timers(input logic t1_given, input logic [31:0] t1,
                             input logic t2_given, input logic [31:0] t2);
    logic [31:0] lease32;
    logic [31:0] half_lease;
    logic [31:0] late_lease;
    logic [31:0] r1;
    logic [31:0] r2;
    lease32    = 32'(held_lease);
    half_lease = lease32 >> 1;
    late_lease = (lease32 * 32'd7) >> 3;
    r1 = t1_given ? t1 : half_lease;
    r2 = t2_given ? t2 : late_lease;
    if (r1 >= lease32 || r2 >= lease32 || r2 <= r1) begin
      r1 = half_lease;
      r2 = late_lease;
    end
    held_renewal   = r1[SEC_W-1:0];
    held_rebinding = r2[SEC_W-1:0];
  endtask

  task automatic apply_offer(input offer_fields_t f, output offer_result_t r);
    logic [31:0] host_mask;
    r = '0;
    r.reason = RSN_OK;
    if (f.cmd == CMD_CAP) begin
      if (f.cap != 32'd0 && 32'(held_lease) > f.cap) begin
        held_lease = f.cap[SEC_W-1:0];
        load_timers(1'b0, 32'd0, 1'b0, 32'd0);
        r.accepted = 1'b1;
      end
    end else begin
      host_mask = ~f.mask;
      if (!host_usable(f.addr)) begin
        r.reason = RSN_BAD_ADDR;
      end else if (!host_usable(f.server)) begin
        r.reason = RSN_BAD_SRV;
      end else if (f.mask == 32'd0 || (host_mask & (host_mask + 32'd1)) != 32'd0) begin
        r.reason = RSN_BAD_MASK;
      end else if (host_mask > 32'd1 &&
                   ((f.addr & host_mask) == 32'd0 || (f.addr & host_mask) == host_mask)) begin
        r.reason = RSN_NET_BCAST;
      end else if (f.lease == 32'd0) begin
        r.reason = RSN_ZERO_LEAS;
      end else begin
        held_lease  = (f.lease < 32'(max_lease)) ? f.lease[SEC_W-1:0] : max_lease;
        held_prefix = PFX_W'($countones(f.mask));
        load_timers(f.t1_given, f.t1, f.t2_given, f.t2);
        r.accepted = 1'b1;
      end
    end
    r.lease     = held_lease;
    r.renewal   = held_renewal;
    r.rebinding = held_rebinding;
    r.prefix    = held_prefix;
  endtask

  always @(posedge clk) begin : watch
    offer_fields_t f;
    offer_result_t want;
    offer_result_t got;
    if (!rst_n) begin
      max_lease      = MAX_LEASE_RESET;
      held_lease     = '0;
      held_renewal   = '0;
      held_rebinding = '0;
      held_prefix    = '0;
      pending_results.delete();
      fail_count     = 0;
      pending        = 0;
    end else begin
      if (cfg_wr_en) begin
        max_lease = cfg_wr_data;
      end
      // Results leave only after their input has passed the block's registers, so pop before push.
      if (out_tvalid && out_tready) begin
        got.accepted  = out_tdata[OUT_ACC_BIT];
        got.reason    = out_tdata[OUT_RSN_LSB +: RSN_W];
        got.lease     = out_tdata[OUT_LEASE_LSB +: SEC_W];
        got.renewal   = out_tdata[OUT_T1_LSB +: SEC_W];
        got.rebinding = out_tdata[OUT_T2_LSB +: SEC_W];
        got.prefix    = out_tdata[OUT_PFX_LSB +: PFX_W];
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result with no expectation waiting: %h", $time, out_tdata);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.accepted !== want.accepted || got.reason !== want.reason ||
              got.lease !== want.lease || got.renewal !== want.renewal ||
              got.rebinding !== want.rebinding || got.prefix !== want.prefix) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch: expected acc=%0d rsn=%0d lease=%0d t1=%0d t2=%0d pfx=%0d",
                       $time, want.accepted, want.reason, want.lease, want.renewal,
                       want.rebinding, want.prefix);
              $display("%0t:                  actual acc=%0d rsn=%0d lease=%0d t1=%0d t2=%0d pfx=%0d",
                       $time, got.accepted, got.reason, got.lease, got.renewal,
                       got.rebinding, got.prefix);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        f.cmd      = in_tuser;
        f.addr     = in_tdata[IN_ADDR_LSB +: ADDR_W];
        f.server   = in_tdata[IN_SERVER_LSB +: ADDR_W];
        f.mask     = in_tdata[IN_MASK_LSB +: ADDR_W];
        f.lease    = in_tdata[IN_LEASE_LSB +: 32];
        f.t1       = in_tdata[IN_T1_LSB +: 32];
        f.t1_given = in_tdata[IN_T1_GIVEN];
        f.t2       = in_tdata[IN_T2_LSB +: 32];
        f.t2_given = in_tdata[IN_T2_GIVEN];
        f.cap      = in_tdata[IN_CAP_LSB +: 32];
        apply_offer(f, want);
        pending_results.push_back(want);
      end
      pending = pending_results.size();
    end
  end

endmodule

>>> tb/sv/tb_dhcp_offer_check_and_timers.sv
// Testbench top for the DHCP offer checker: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_dhcp_offer_check_and_timers;
  import dhcpoc_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the deliberate receiver hold-off below.
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 64;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [SEC_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  // tdata, lowest bit up: offered_address, server_address, subnet_mask, lease_time,
  // renewal_time, renewal_given, rebinding_time, rebinding_given, cap_seconds, zero padding.
  logic [IN_TDATA_W-1:0]  in_tdata;
  // tuser: command.
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // tdata, lowest bit up: accepted, reject_reason, lease_out, renewal_out, rebinding_out,
  // prefix_out, zero padding.
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;

  // Flow-control knobs, in percent of cycles spent idle, changed per phase.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic        hold_rq;
  // Set by the receiver once that hold-off has been served.
  logic        hold_done;
  // Stimulus-side copy of the maximum lease, used only to shape timer values.
  logic [SEC_W-1:0] max_lease_set;
  int          stall_cycles = 0;

  dhcp_offer_check_and_timers uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  offer_lease_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // 8 ns period clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: any transfer on either channel restarts the count. The inputs of
  // the handshake are sampled before the edge updates them, so this is race free.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver. Each falling edge decides whether the next rising edge can take
  // a result. When a hold-off is requested it keeps tready low for a long
  // stretch, counted here, so the block's queue fills and it stops taking input.
  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rq && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one item and returns at the rising edge where it transfers. The
  // sender may idle for some cycles first; valid is only ever changed once per
  // falling edge, and it stays high between back-to-back items.
  task automatic push_item(input logic cmd, input logic [31:0] addr,
                           input logic [31:0] server, input logic [31:0] mask,
                           input logic [31:0] lease, input logic [31:0] t1,
                           input logic t1_given, input logic [31:0] t2,
                           input logic t2_given, input logic [31:0] cap);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_ADDR_LSB +: ADDR_W]   = addr;
    word[IN_SERVER_LSB +: ADDR_W] = server;
    word[IN_MASK_LSB +: ADDR_W]   = mask;
    word[IN_LEASE_LSB +: 32]      = lease;
    word[IN_T1_LSB +: 32]         = t1;
    word[IN_T1_GIVEN]             = t1_given;
    word[IN_T2_LSB +: 32]         = t2;
    word[IN_T2_GIVEN]             = t2_given;
    word[IN_CAP_LSB +: 32]        = cap;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = word;
    in_tuser  = cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted result has been taken,
  // then lets the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write while the block is idle.
  task automatic write_max_lease(input logic [SEC_W-1:0] value);
    drain();
    cfg_wr_en     = 1'b1;
    cfg_wr_data   = value;
    max_lease_set = value;
    @(negedge clk);
    cfg_wr_en     = 1'b0;
  endtask

  // An address that fails the host check: zero, loopback, multicast or all ones.
  function automatic logic [31:0] unusable_host(input int unsigned kind);
    logic [31:0] r;
    r = $urandom;
    case (kind)
      0:       return 32'd0;
      1:       return {LOOPBACK_NET, r[23:0]};
      2:       return {MCAST_NIBBLE, r[27:0]};
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Moves a random address off the loopback and multicast ranges.
  function automatic logic [31:0] host_fix(input logic [31:0] a);
    if (a[31:28] == MCAST_NIBBLE) begin
      a[28] = 1'b1;
    end
    if (a[31:24] == LOOPBACK_NET) begin
      a[24] = 1'b0;
    end
    return a;
  endfunction

  // Mostly well-formed offers with random content, so that most items reach
  // the lease and timer logic; the rest carry one broken field, and a share
  // are cap commands.
  task automatic random_item();
    logic        cmd;
    logic        t1_given;
    logic        t2_given;
    logic [31:0] addr;
    logic [31:0] server;
    logic [31:0] mask;
    logic [31:0] host_part;
    logic [31:0] lease;
    logic [31:0] eff_lease;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] cap;
    int unsigned pfx;
    cmd  = ($urandom_range(99) < 15) ? CMD_CAP : CMD_CHECK;
    pfx  = ($urandom_range(9) == 0) ? $urandom_range(31, 32) : $urandom_range(1, 30);
    mask = 32'hFFFF_FFFF << (32 - pfx);
    host_part = ~mask;
    addr = host_fix($urandom);
    if (pfx <= 30 && ((addr & host_part) == 32'd0 || (addr & host_part) == host_part)) begin
      addr[0] = ~addr[0];
    end
    server = host_fix($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: lease = $urandom_range(1, 5000);
      4, 5, 6:    lease = $urandom_range(1, 20'hFFFFF);
      7, 8:       lease = $urandom;
      default:    lease = 32'hFFFF_FFFF;
    endcase
    eff_lease = (lease < 32'(max_lease_set)) ? lease : 32'(max_lease_set);
    t1_given  = ($urandom_range(3) != 0);
    t2_given  = ($urandom_range(3) != 0);
    // Ordered server timers below the clamped lease are the interesting case.
    if (eff_lease >= 32'd3 && $urandom_range(9) < 7) begin
      t1 = $urandom_range(0, eff_lease - 2);
      t2 = $urandom_range(t1 + 1, eff_lease - 1);
    end else begin
      t1 = $urandom;
      t2 = ($urandom_range(3) == 0) ? t1 : $urandom;
    end
    case ($urandom_range(9))
      0, 1:          cap = 32'd0;
      2, 3, 4, 5, 6: cap = $urandom_range(1, 20'hFFFFF);
      default:       cap = $urandom;
    endcase
    if (cmd == CMD_CHECK && $urandom_range(99) < 20) begin
      case ($urandom_range(7))
        0: addr   = unusable_host($urandom_range(3));
        1: server = unusable_host($urandom_range(3));
        2: mask   = 32'd0;
        3: mask   = mask ^ (32'd1 << $urandom_range(31));
        4: addr   = addr & mask;
        5: addr   = addr | host_part;
        6: lease  = 32'd0;
        default: server = 32'd0;
      endcase
    end
    push_item(cmd, addr, server, mask, lease, t1, t1_given, t2, t2_given, cap);
  endtask

  // Directed items at the reset maximum of 604800 s.
  task automatic directed_items();
    // Cap on the empty state leaves it alone.
    push_item(CMD_CAP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 32'd5);
    // Good offers on a /24: default timers, server timers kept, and the
    // various ways the server timers get replaced by the defaults.
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd1000, 1'b1, 32'd2000, 1'b1, 32'd0);
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd3200, 1'b1, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd100, 1'b1, 32'd0);
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd1500, 1'b1, 32'd1500, 1'b1, 32'd0);
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd1000, 1'b1, 32'd3600, 1'b1, 32'd0);
    // Longest lease is clamped to the maximum.
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1, 32'hFFFF_FFFF);
    // Unusable offered addresses; the last one also has a bad mask.
    push_item(CMD_CHECK, 32'd0, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'h7F000001, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hE0000001, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hFFFF_FFFF, 32'hC0A80101, 32'd0, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    // Absent and multicast server.
    push_item(CMD_CHECK, 32'hC0A8010A, 32'd0, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hEFFFFFFF, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    // Absent and non-contiguous masks.
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'd0, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFF00FF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    // Network and broadcast addresses of the subnet.
    push_item(CMD_CHECK, 32'hC0A80100, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hC0A801FF, 32'hC0A80101, 32'hFFFFFF00, 32'd3600,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    // A /31 and a /32 are exempt from the network and broadcast check.
    push_item(CMD_CHECK, 32'hC0A80100, 32'hC0A80101, 32'hFFFFFFFE, 32'd1,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CHECK, 32'hC0A801FF, 32'hC0A80101, 32'hFFFF_FFFF, 32'd7200,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    // Widest mask, and a server near the top of the address space.
    push_item(CMD_CHECK, 32'h40000001, 32'hFFFFFFFE, 32'h80000000, 32'd100,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    // Zero lease.
    push_item(CMD_CHECK, 32'hC0A8010A, 32'hC0A80101, 32'hFFFFFF00, 32'd0,
              32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    // Caps: zero, not below the stored lease, and two that shorten it.
    push_item(CMD_CAP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
    push_item(CMD_CAP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 32'd1000000);
    push_item(CMD_CAP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 32'd40);
    push_item(CMD_CAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd39);
  endtask

  // Main stimulus. Each random phase sets a new maximum lease; the extremes
  // (largest, one and zero) get their own phases. Flow control runs sender
  // light and receiver heavy first, then the reverse, then with no idling.
  initial begin : stimulus
    logic [SEC_W-1:0] phase_max[6];
    int               phase_len[6];
    phase_max = '{20'hFFFFF, 20'd4096, 20'd1, 20'd0, 20'd0, MAX_LEASE_RESET};
    phase_len = '{250, 250, 100, 250, 100, 250};
    phase_max[3] = $urandom_range(2, 20'hFFFFE);
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = CMD_CHECK;
    hold_rq       = 1'b0;
    tx_idle_pct   = 25;
    rx_idle_pct   = 64;
    max_lease_set = MAX_LEASE_RESET;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    directed_items();

    for (int p = 0; p < 6; p++) begin
      write_max_lease(phase_max[p]);
      tx_idle_pct = (p < 2) ? 25 : (p < 4) ? 64 : 0;
      rx_idle_pct = (p < 2) ? 64 : (p < 4) ? 25 : 0;
      for (int i = 0; i < phase_len[p]; i++) begin
        // One long receiver stall in the first phase while items keep coming.
        if (p == 0 && i == 40) begin
          hold_rq = 1'b1;
        end
        random_item();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/dhcpoc_pkg.sv
src/dhcpoc_front.sv
src/dhcpoc_queue.sv
src/dhcpoc_back.sv
src/dhcp_offer_check_and_timers.sv
src/dhcpoc_checker.sv
tb/sv/offer_lease_checker.sv
tb/sv/tb_dhcp_offer_check_and_timers.sv
